>>> rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// Infix to postfix converter package
// Shared constants, character classes and the controller/datapath interface
// types of the operator-stack converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  // operator stack geometry
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);

  // character codes
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] DIGIT_LO = 8'd48;
  localparam logic [7:0] DIGIT_HI = 8'd57;
  localparam logic [7:0] UPPER_LO = 8'd65;
  localparam logic [7:0] UPPER_HI = 8'd90;
  localparam logic [7:0] LOWER_LO = 8'd97;
  localparam logic [7:0] LOWER_HI = 8'd122;

  // status codes of the closing item
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_UNBALANCED = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW   = 2'd2;

  typedef enum logic [1:0] {
    CLS_OPERAND,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER
  } char_class_e;

  // sort a character into operand, parentheses or operator
  function automatic char_class_e classify(logic [7:0] ch);
    char_class_e cls;
    if ((ch >= DIGIT_LO && ch <= DIGIT_HI) || (ch >= UPPER_LO && ch <= UPPER_HI) ||
        (ch >= LOWER_LO && ch <= LOWER_HI)) begin
      cls = CLS_OPERAND;
    end else if (ch == CH_OPEN) begin
      cls = CLS_OPEN;
    end else if (ch == CH_CLOSE) begin
      cls = CLS_CLOSE;
    end else begin
      cls = CLS_OPER;
    end
    return cls;
  endfunction

  // precedence shifted up by one so it fits unsigned: anything else ranks 0
  function automatic logic [1:0] prec_rank(logic [7:0] ch);
    logic [1:0] rank;
    if (ch == CH_CARET) begin
      rank = 2'd3;
    end else if (ch == CH_STAR || ch == CH_SLASH) begin
      rank = 2'd2;
    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
      rank = 2'd1;
    end else begin
      rank = 2'd0;
    end
    return rank;
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic       latch_in;
    logic       push;
    logic       pop;
    logic       clear_cnt;
    logic       emit_top;
    logic       emit_in;
    logic       emit_status;
    logic [1:0] status;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    char_class_e cls;
    logic        end_expr;
    logic        cnt_zero;
    logic        cnt_full;
    logic        top_open;
    logic        top_pops;
    logic        out_free;
  } dp_sts_t;

endpackage

>>> rtl/itp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module itp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/itp_dpath.sv
// ----------------------------------------------------------------------------
// Converter datapath
// Holds the current character, the operator stack with its count and the
// output register, and acts on the controller's commands.
// ----------------------------------------------------------------------------
module itp_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      in_char_i,
  input  logic            end_of_expr_i,
  input  itp_pkg::dp_cmd_t cmd_i,
  output itp_pkg::dp_sts_t sts_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            is_char_o,
  output logic [1:0]      status_o,
  output logic            last_o
);
  import itp_pkg::*;

  logic [7:0]       ch_q;
  logic             end_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_m1;
  logic [7:0]       top;
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             is_char_q;
  logic [1:0]       status_q;
  logic             last_q;
  logic             out_load;

  // latched input character
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      ch_q  <= in_char_i;
      end_q <= end_of_expr_i;
    end
  end

  // stack count
  assign cnt_m1 = cnt_q - CNT_W'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear_cnt) begin
      cnt_d = '0;
    end else if (cmd_i.push) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      cnt_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // operator stack storage, always reading the top entry
  itp_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(cnt_q[IDX_W-1:0]),
    .wdata_i(ch_q),
    .raddr_i(cnt_m1[IDX_W-1:0]),
    .rdata_o(top)
  );

  // output register
  assign out_load = cmd_i.emit_top | cmd_i.emit_in | cmd_i.emit_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (cmd_i.emit_status) begin
        out_char_q <= 8'd0;
        is_char_q  <= 1'b0;
        status_q   <= cmd_i.status;
        last_q     <= 1'b1;
      end else begin
        out_char_q <= cmd_i.emit_top ? top : ch_q;
        is_char_q  <= 1'b1;
        status_q   <= STATUS_OK;
        last_q     <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign is_char_o   = is_char_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  // status toward the controller
  assign sts_o.cls      = classify(ch_q);
  assign sts_o.end_expr = end_q;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.cnt_full = (cnt_q == CNT_W'(STACK_DEPTH));
  assign sts_o.top_open = (top == CH_OPEN);
  assign sts_o.top_pops = (prec_rank(ch_q) <= prec_rank(top));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

>>> rtl/itp_ctrl.sv
// ----------------------------------------------------------------------------
// Converter controller
// State machine that steps each character through classify, pop, push and
// end-of-expression flush, and raises error status items.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  itp_pkg::dp_sts_t sts_i,
  output itp_pkg::dp_cmd_t cmd_o
);
  import itp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,
    S_POP_RD,
    S_POP_CHK,
    S_PUSH,
    S_FLUSH_RD,
    S_FLUSH_CHK,
    S_ERR
  } state_e;

  state_e     state_q, state_d;
  logic       skip_q, skip_d;
  logic [1:0] err_q, err_d;
  state_e     after_char;

  // where to go once a character has been handled
  assign after_char = sts_i.end_expr ? S_FLUSH_RD : S_IDLE;

  // next state and commands
  always_comb begin
    state_d = state_q;
    skip_d  = skip_q;
    err_d   = err_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_PROC;
        end
      end
      S_PROC: begin
        if (skip_q) begin
          if (sts_i.end_expr) begin
            skip_d = 1'b0;
          end
          state_d = S_IDLE;
        end else begin
          case (sts_i.cls)
            CLS_OPERAND: begin
              if (sts_i.out_free) begin
                cmd_o.emit_in = 1'b1;
                state_d       = after_char;
              end
            end
            CLS_OPEN: state_d = S_PUSH;
            default:  state_d = S_POP_RD;
          endcase
        end
      end
      S_POP_RD: begin
        if (!sts_i.cnt_zero) begin
          state_d = S_POP_CHK;
        end else if (sts_i.cls == CLS_CLOSE) begin
          err_d   = STATUS_UNBALANCED;
          state_d = S_ERR;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_POP_CHK: begin
        if (sts_i.cls == CLS_CLOSE && sts_i.top_open) begin
          // matching open parenthesis is dropped
          cmd_o.pop = 1'b1;
          state_d   = after_char;
        end else if (sts_i.cls == CLS_CLOSE || sts_i.top_pops) begin
          if (sts_i.out_free) begin
            cmd_o.emit_top = 1'b1;
            cmd_o.pop      = 1'b1;
            state_d        = S_POP_RD;
          end
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts_i.cnt_full) begin
          err_d   = STATUS_OVERFLOW;
          state_d = S_ERR;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = after_char;
        end
      end
      S_FLUSH_RD: begin
        if (!sts_i.cnt_zero) begin
          state_d = S_FLUSH_CHK;
        end else if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          cmd_o.status      = STATUS_OK;
          state_d           = S_IDLE;
        end
      end
      S_FLUSH_CHK: begin
        if (sts_i.top_open) begin
          // open parenthesis left at the end
          err_d   = STATUS_UNBALANCED;
          state_d = S_ERR;
        end else if (sts_i.out_free) begin
          cmd_o.emit_top = 1'b1;
          cmd_o.pop      = 1'b1;
          state_d        = S_FLUSH_RD;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          cmd_o.status      = err_q;
          cmd_o.clear_cnt   = 1'b1;
          skip_d            = !sts_i.end_expr;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and held flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      skip_q  <= 1'b0;
      err_q   <= STATUS_OK;
    end else begin
      state_q <= state_d;
      skip_q  <= skip_d;
      err_q   <= err_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// Infix to postfix converter
// Shunting-yard conversion of a character stream with an operator stack held
// in a RAM, split into a controller state machine and a datapath.
// ----------------------------------------------------------------------------
// One character is taken at a time. An operand is emitted from the processing
// step, '(' goes on to the push step, and ')' or an operator goes through the
// pop steps: each pop reads the top through the stack RAM's registered read
// port in a read state and compares it in a check state, one entry at a time.
// A character that closes the expression goes on to a flush step that pops
// every operator left, and an error adds a status item.
// Results leave through one output register, so a stalled output holds the
// work until it is taken. Items that follow an error are taken and give
// nothing, up to and including the item that closes the expression. The stack
// needs no clearing after reset.
module infix_to_postfix_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_expr_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       is_char_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  import itp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  itp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // stack and output register
  itp_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_char_i    (in_char_i),
    .end_of_expr_i(end_of_expr_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .is_char_o    (is_char_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule
